### rtl/rmsn_pkg.sv
// ----------------------------------------------------------------------------
// rmsn_pkg
// Shared widths and types of the RMS normalizer.
// ----------------------------------------------------------------------------
package rmsn_pkg;

  localparam int unsigned SUM_W     = 37;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned EPS_W     = 32;
  localparam int unsigned GAIN_W    = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd168;

  // One closed vector: its sum of squares and its element count.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } desc_t;

endpackage

### rtl/rms_normalizer.sv
// ----------------------------------------------------------------------------
// rms_normalizer
// Root mean square normalization of a vector of weighted fixed-point samples.
// ----------------------------------------------------------------------------
// Elements are taken one beat per cycle and stored in one of two banks, so a
// new vector loads while the previous one is still being worked off. When a
// vector closes (end mark, or MAX_LEN elements) the back end takes its
// descriptor, divides for the mean square and adds epsilon; unless that sum
// is zero or one it divides for the reciprocal and takes its square root, all
// in one shared bit-serial divider and a bit-pair root unit. It then emits
// the results one at a time, each through the store read, the sample-gain
// product and three partial products of the reciprocal multiply. Loading
// stalls only when both banks hold vectors whose results are not all delivered.
module rms_normalizer #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic signed [rmsn_pkg::GAIN_W-1:0]  in_gain,
  input  logic                                in_end_of_vector,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [SAMPLE_BITS-1:0]              out_normalized,
  output logic [rmsn_pkg::IDX_W-1:0]          out_position,
  output logic                                out_final_res,
  output logic                                out_clipped,
  input  logic                                cfg_wr_en,
  input  logic [rmsn_pkg::EPS_W-1:0]          cfg_wr_data
);

  logic                                       mem_we;
  logic [rmsn_pkg::IDX_W:0]                   mem_waddr;
  logic [SAMPLE_BITS+rmsn_pkg::GAIN_W-1:0]    mem_wdata;
  logic                                       q_valid;
  rmsn_pkg::desc_t                            q_head;
  logic                                       q_pop;
  logic                                       bank_release;

  rmsn_front #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_sample        (in_sample),
    .in_gain          (in_gain),
    .in_end_of_vector (in_end_of_vector),
    .in_full          (in_full),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .bank_release     (bank_release)
  );

  rmsn_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .bank_release   (bank_release),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_normalized (out_normalized),
    .out_position   (out_position),
    .out_final_res  (out_final_res),
    .out_clipped    (out_clipped)
  );

endmodule

### rtl/rmsn_front.sv
// ----------------------------------------------------------------------------
// rmsn_front
// Accepts elements, writes them to the element store, accumulates squares and
// queues one descriptor per closed vector.
// ----------------------------------------------------------------------------
module rmsn_front #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_push,
  input  logic signed [SAMPLE_BITS-1:0]             in_sample,
  input  logic signed [rmsn_pkg::GAIN_W-1:0]        in_gain,
  input  logic                                      in_end_of_vector,
  output logic                                      in_full,
  output logic                                      mem_we,
  output logic [rmsn_pkg::IDX_W:0]                  mem_waddr,
  output logic [SAMPLE_BITS+rmsn_pkg::GAIN_W-1:0]   mem_wdata,
  output logic                                      q_valid,
  output rmsn_pkg::desc_t                           q_head,
  input  logic                                      q_pop,
  input  logic                                      bank_release
);

  localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

  logic                         bank_r, bank_nxt;
  logic [rmsn_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                   used_r, used_nxt;
  logic                         s2_valid_r;
  logic                         s2_close_r;
  logic [SQ_W-1:0]              s2_sq_r;
  logic [rmsn_pkg::CNT_W-1:0]   s2_cnt_r;
  logic [rmsn_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  rmsn_pkg::desc_t              q_data_r [2];
  logic                         q_wr_r, q_rd_r;
  logic [1:0]                   q_cnt_r;

  logic                         accept;
  logic                         close;
  logic [SAMPLE_BITS-1:0]       mag;
  logic [rmsn_pkg::CNT_W-1:0]   cnt_inc;
  logic [rmsn_pkg::SUM_W-1:0]   sum_new;
  logic                         q_push;

  // A bank stays reserved from the beat that closes its vector until the
  // back end has delivered its last result.
  assign in_full = (used_r == 2'd2);
  assign accept  = in_push && !in_full;
  assign cnt_inc = cnt_r + 1'b1;
  assign close   = in_end_of_vector || (cnt_inc == rmsn_pkg::CNT_W'(MAX_LEN));
  assign mag     = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

  assign mem_we    = accept;
  assign mem_waddr = {bank_r, cnt_r[rmsn_pkg::IDX_W-1:0]};
  assign mem_wdata = {in_sample, in_gain};

  assign sum_new = sum_r + rmsn_pkg::SUM_W'(s2_sq_r);
  assign q_push  = s2_valid_r && s2_close_r;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_head  = q_data_r[q_rd_r];

  always_comb begin
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    used_nxt = used_r;
    sum_nxt  = sum_r;
    if (accept) begin
      cnt_nxt = close ? '0 : cnt_inc;
      if (close) begin
        bank_nxt = ~bank_r;
      end
    end
    if (accept && close && !bank_release) begin
      used_nxt = used_r + 2'd1;
    end else if (bank_release && !(accept && close)) begin
      used_nxt = used_r - 2'd1;
    end
    if (s2_valid_r) begin
      sum_nxt = s2_close_r ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      cnt_r      <= '0;
      used_r     <= 2'd0;
      sum_r      <= '0;
      s2_valid_r <= 1'b0;
      q_wr_r     <= 1'b0;
      q_rd_r     <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      bank_r     <= bank_nxt;
      cnt_r      <= cnt_nxt;
      used_r     <= used_nxt;
      sum_r      <= sum_nxt;
      s2_valid_r <= accept;
      if (q_push) begin
        q_wr_r <= ~q_wr_r;
      end
      if (q_pop) begin
        q_rd_r <= ~q_rd_r;
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_close_r <= close;
      s2_sq_r    <= mag * mag;
      s2_cnt_r   <= cnt_inc;
    end
    if (q_push) begin
      q_data_r[q_wr_r].sum   <= sum_new;
      q_data_r[q_wr_r].count <= s2_cnt_r;
    end
  end

endmodule

### rtl/rmsn_back.sv
// ----------------------------------------------------------------------------
// rmsn_back
// Holds the element store. For each closed vector it divides out the mean
// square, forms the inverse square root and emits the scaled elements.
// ----------------------------------------------------------------------------
module rmsn_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      mem_we,
  input  logic [rmsn_pkg::IDX_W:0]                  mem_waddr,
  input  logic [SAMPLE_BITS+rmsn_pkg::GAIN_W-1:0]   mem_wdata,
  input  logic                                      q_valid,
  input  rmsn_pkg::desc_t                           q_head,
  output logic                                      q_pop,
  output logic                                      bank_release,
  input  logic                                      cfg_wr_en,
  input  logic [rmsn_pkg::EPS_W-1:0]                cfg_wr_data,
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output logic [SAMPLE_BITS-1:0]                    out_normalized,
  output logic [rmsn_pkg::IDX_W-1:0]                out_position,
  output logic                                      out_final_res,
  output logic                                      out_clipped
);

  localparam int unsigned MW    = SAMPLE_BITS + rmsn_pkg::GAIN_W;
  localparam int unsigned PM_W  = SAMPLE_BITS + 15;
  localparam int unsigned ACC_W = PM_W + 33;
  localparam int unsigned R_W   = ACC_W - 33;
  localparam int unsigned DVS_W = 38;
  localparam int unsigned DVD_W = 65;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_EPS  = 8'b0000_0100,
    S_SQRT = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_PP   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t                       state_r;
  logic [rmsn_pkg::EPS_W-1:0]   eps_r;
  logic [MW-1:0]                mem [2**(rmsn_pkg::IDX_W+1)];
  logic [MW-1:0]                rd_r;
  logic                         bank_r;
  logic [rmsn_pkg::CNT_W-1:0]   n_r;
  logic [rmsn_pkg::IDX_W-1:0]   k_r;
  logic                         phase_r;
  logic [6:0]                   step_r;
  logic [DVD_W-1:0]             dvd_r;
  logic [DVD_W-1:0]             quo_r;
  logic [DVS_W-1:0]             rem_r;
  logic [DVS_W-1:0]             dvs_r;
  logic [63:0]                  sq_n_r;
  logic [63:0]                  sq_res_r;
  logic [63:0]                  sq_bit_r;
  logic [32:0]                  inv_r;
  logic signed [MW-1:0]         p_r;
  logic [1:0]                   pp_r;
  logic [ACC_W-1:0]             acc_r;
  logic                         out_valid_r;
  logic [SAMPLE_BITS-1:0]       out_norm_r;
  logic [rmsn_pkg::IDX_W-1:0]   out_pos_r;
  logic                         out_fin_r;
  logic                         out_clip_r;

  logic [DVS_W:0]               rem_sh;
  logic                         qbit;
  logic [DVS_W-1:0]             rem_step;
  logic [DVD_W-1:0]             quo_step;
  logic [DVS_W-1:0]             ms;
  logic [63:0]                  sq_trial;
  logic                         neg;
  logic [PM_W-1:0]              pm;
  logic [10:0]                  chunk;
  logic [ACC_W-1:0]             partial;
  logic [R_W-1:0]               r_round;
  logic [R_W-1:0]               r_sat;
  logic                         clip;
  logic [SAMPLE_BITS-1:0]       v_out;
  logic                         last;
  logic                         slot_free;

  // Restoring divider, one quotient bit a cycle.
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign qbit     = (rem_sh >= {1'b0, dvs_r});
  assign rem_step = qbit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
  assign quo_step = {quo_r[DVD_W-2:0], qbit};

  assign ms       = {1'b0, quo_r[rmsn_pkg::SUM_W-1:0]} + DVS_W'(eps_r);
  assign sq_trial = sq_res_r + sq_bit_r;

  assign neg = p_r[MW-1];
  assign pm  = neg ? PM_W'(-p_r) : PM_W'(p_r);

  always_comb begin
    case (pp_r)
      2'd0:    chunk = inv_r[10:0];
      2'd1:    chunk = inv_r[21:11];
      default: chunk = inv_r[32:22];
    endcase
  end

  assign partial = ACC_W'(pm * chunk) << (11 * pp_r);

  // Rounding to nearest, ties away from zero, on the magnitude.
  assign r_round = R_W'((acc_r + (ACC_W'(1) << 33)) >> 34);

  always_comb begin
    clip  = 1'b0;
    r_sat = r_round;
    if (neg) begin
      if (r_round > (R_W'(1) << (SAMPLE_BITS - 1))) begin
        r_sat = R_W'(1) << (SAMPLE_BITS - 1);
        clip  = 1'b1;
      end
      v_out = SAMPLE_BITS'(-r_sat);
    end else begin
      if (r_round > ((R_W'(1) << (SAMPLE_BITS - 1)) - 1'b1)) begin
        r_sat = (R_W'(1) << (SAMPLE_BITS - 1)) - 1'b1;
        clip  = 1'b1;
      end
      v_out = SAMPLE_BITS'(r_sat);
    end
  end

  assign last      = ({1'b0, k_r} + 1'b1) == n_r;
  assign slot_free = !out_valid_r || out_pop;

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign bank_release = (state_r == S_OUT) && slot_free && last;

  assign out_empty      = !out_valid_r;
  assign out_normalized = out_norm_r;
  assign out_position   = out_pos_r;
  assign out_final_res  = out_fin_r;
  assign out_clipped    = out_clip_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[{bank_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eps_r       <= rmsn_pkg::EPS_RESET;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if ((state_r == S_OUT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == 7'd1) begin
            state_r <= phase_r ? S_SQRT : S_EPS;
          end
        end
        S_EPS: begin
          state_r <= (ms <= DVS_W'(1)) ? S_RD : S_DIV;
        end
        S_SQRT: begin
          if (sq_bit_r == 64'd1) begin
            state_r <= S_RD;
          end
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_PP;
        S_PP: begin
          if (pp_r == 2'd2) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            if (last) begin
              bank_r  <= ~bank_r;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r     <= q_head.count;
        k_r     <= '0;
        phase_r <= 1'b0;
        step_r  <= 7'(rmsn_pkg::SUM_W);
        dvd_r   <= {q_head.sum, (DVD_W - rmsn_pkg::SUM_W)'(0)};
        dvs_r   <= DVS_W'(q_head.count);
        rem_r   <= '0;
        quo_r   <= '0;
      end
      S_DIV: begin
        dvd_r  <= dvd_r << 1;
        rem_r  <= rem_step;
        quo_r  <= quo_step;
        step_r <= step_r - 7'd1;
        sq_n_r   <= quo_step[63:0];
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
      end
      S_EPS: begin
        // A mean square plus epsilon of zero or one gives the full-scale reciprocal.
        inv_r   <= 33'd1 << 32;
        phase_r <= 1'b1;
        step_r  <= 7'(DVD_W);
        dvd_r   <= DVD_W'(1) << (DVD_W - 1);
        dvs_r   <= ms;
        rem_r   <= '0;
        quo_r   <= '0;
      end
      S_SQRT: begin
        if (sq_n_r >= sq_trial) begin
          sq_n_r   <= sq_n_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          inv_r    <= 33'((sq_res_r >> 1) + sq_bit_r);
        end else begin
          sq_res_r <= sq_res_r >> 1;
          inv_r    <= 33'(sq_res_r >> 1);
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_MUL: begin
        p_r  <= $signed(rd_r[MW-1:rmsn_pkg::GAIN_W]) *
                $signed(rd_r[rmsn_pkg::GAIN_W-1:0]);
        pp_r <= 2'd0;
      end
      S_PP: begin
        acc_r <= (pp_r == 2'd0) ? partial : acc_r + partial;
        pp_r  <= pp_r + 2'd1;
      end
      S_OUT: begin
        if (slot_free) begin
          out_norm_r <= v_out;
          out_pos_r  <= k_r;
          out_fin_r  <= last;
          out_clip_r <= clip;
          k_r        <= k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sim/rms_normalizer_tb.sv
// ----------------------------------------------------------------------------
// rms_normalizer_tb
// Self-checking bench for the RMS normalizer. Elements are streamed in as
// vectors. A local model stores each vector, forms its mean square and its
// reciprocal root, and queues the normalized results. Each result beat is
// checked against that queue. Both sides idle in random bursts, and once
// the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module rms_normalizer_tb;

  localparam int unsigned VEC_MAX = 64;
  localparam int unsigned LIMIT   = 900000;
  localparam int unsigned SETTLE  = 200;

  typedef struct {
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic               eov;
  } element_t;

  typedef struct {
    logic [15:0] norm;
    logic [5:0]  pos;
    logic        last;
    logic        clip;
  } norm_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic signed [15:0] in_sample = '0;
  logic signed [rmsn_pkg::GAIN_W-1:0] in_gain = '0;
  logic in_end_of_vector = 1'b0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [15:0] out_normalized;
  logic [rmsn_pkg::IDX_W-1:0] out_position;
  logic out_final_res;
  logic out_clipped;
  logic cfg_wr_en = 1'b0;
  logic [rmsn_pkg::EPS_W-1:0] cfg_wr_data = '0;

  element_t   pending_elems[$];
  norm_beat_t norm_expected[$];

  // Local copy of the block's vector state.
  logic signed [15:0] sample_mem [VEC_MAX];
  logic signed [15:0] gain_mem [VEC_MAX];
  int unsigned        elem_count = 0;
  logic [36:0]        sum_sq = '0;
  logic [31:0]        eps_model = rmsn_pkg::EPS_RESET;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          beat_taken = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;

  rms_normalizer #(
    .MAX_LEN    (VEC_MAX),
    .SAMPLE_BITS(16)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_sample       (in_sample),
    .in_gain         (in_gain),
    .in_end_of_vector(in_end_of_vector),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_normalized  (out_normalized),
    .out_position    (out_position),
    .out_final_res   (out_final_res),
    .out_clipped     (out_clipped),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitpos;
    res = '0;
    bitpos = 64'h1 << 62;
    while (bitpos > n) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (n >= res + bitpos) begin
        n = n - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res;
  endfunction

  // Closes the stored vector and queues one result per element.
  task automatic close_vector();
    logic [63:0] mean_sq;
    logic [63:0] inv;
    logic [64:0] quot;
    longint      prod;
    logic [63:0] mag;
    logic [63:0] r;
    bit          neg;
    norm_beat_t  nb;
    mean_sq = 64'(sum_sq / elem_count) + 64'(eps_model);
    if (mean_sq <= 1) begin
      inv = 64'h1 << 32;
    end else begin
      quot = (65'h1 << 64) / mean_sq;
      inv = int_root(quot[63:0]);
    end
    for (int k = 0; k < elem_count; k++) begin
      prod = longint'(sample_mem[k]) * longint'(gain_mem[k]);
      neg = prod < 0;
      mag = neg ? 64'(-prod) : 64'(prod);
      r = (mag * inv + (64'h1 << 33)) >> 34;
      nb.clip = 1'b0;
      if (neg && r > 64'd32768) begin
        r = 64'd32768;
        nb.clip = 1'b1;
      end else if (!neg && r > 64'd32767) begin
        r = 64'd32767;
        nb.clip = 1'b1;
      end
      nb.norm = neg ? 16'(-r) : r[15:0];
      nb.pos = 6'(k);
      nb.last = (k + 1 == elem_count);
      norm_expected.push_back(nb);
    end
    elem_count = 0;
    sum_sq = '0;
  endtask

  task automatic take_element(logic signed [15:0] s, logic signed [15:0] g, logic eov);
    logic [15:0] mag;
    mag = s < 0 ? 16'(-s) : 16'(s);
    sample_mem[elem_count] = s;
    gain_mem[elem_count] = g;
    sum_sq = sum_sq + 37'(32'(mag) * 32'(mag));
    elem_count++;
    if (eov || elem_count == VEC_MAX) close_vector();
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Input beats and result beats are both taken at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("rms_normalizer_tb: FAIL");
      $finish;
    end
    if (rst_n && in_push && !in_full) begin
      take_element(in_sample, in_gain, in_end_of_vector);
      beat_taken = 1'b1;
    end
    if (rst_n && out_pop && !out_empty) begin
      if (norm_expected.size() == 0) begin
        report("unexpected result, position", out_position, -1);
      end else begin
        norm_beat_t nb;
        nb = norm_expected.pop_front();
        if (out_normalized !== nb.norm)
          report("normalized", $signed(out_normalized), $signed(nb.norm));
        if (out_position !== nb.pos) report("position", out_position, nb.pos);
        if (out_final_res !== nb.last) report("final_res", out_final_res, nb.last);
        if (out_clipped !== nb.clip) report("clipped", out_clipped, nb.clip);
      end
    end
  end

  always @(negedge clk) begin
    if (beat_taken) begin
      void'(pending_elems.pop_front());
      beat_taken = 1'b0;
    end
    if (!rst_n || pending_elems.size() == 0) begin
      in_push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      in_push <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(1, 18);
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_sample <= pending_elems[0].sample;
      in_gain <= pending_elems[0].gain;
      in_end_of_vector <= pending_elems[0].eov;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 500;
      out_pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 18);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic add_elem(int s, int g, bit eov);
    element_t e;
    e.sample = 16'(s);
    e.gain = 16'(g);
    e.eov = eov;
    pending_elems.push_back(e);
  endtask

  task automatic write_eps(logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    eps_model = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_elems.size() != 0 || norm_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Random vectors: mostly short, some filled to the length limit.
  task automatic add_vectors(int unsigned n_items);
    int unsigned added;
    int unsigned len;
    bit          full_len;
    added = 0;
    while (added < n_items) begin
      full_len = $urandom_range(0, 11) == 0;
      len = full_len ? VEC_MAX : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        add_elem(rand_value(), rand_value(),
                 (i == len - 1) && (!full_len || $urandom_range(0, 1)));
      added += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes of both fields, then two large samples among zeros.
    write_eps(32'd168);
    add_elem(32767, 32767, 0);
    add_elem(-32768, -32768, 0);
    add_elem(-32768, 32767, 0);
    add_elem(0, 0, 0);
    add_elem(1, -1, 1);
    add_elem(32767, 32767, 0);
    for (int i = 0; i < 14; i++) add_elem(0, 0, 0);
    add_elem(-32768, 32767, 1);
    drain();

    // A zero mean square with no epsilon.
    write_eps(32'd0);
    add_elem(0, 32767, 0);
    add_elem(0, -32768, 0);
    add_elem(0, 0, 1);
    add_vectors(40);
    drain();

    write_eps(32'hFFFF_FFFF);
    add_vectors(100);
    drain();

    write_eps($urandom());
    add_vectors(160);
    hold_req = 1'b1;
    drain();

    quiet = 1'b1;
    write_eps(rmsn_pkg::EPS_RESET);
    add_vectors(130);
    drain();

    if (error_count == 0) begin
      $display("rms_normalizer_tb: PASS");
    end else begin
      $display("rms_normalizer_tb: FAIL");
    end
    $finish;
  end

endmodule
